// ===== rtl/micdc_pkg.sv =====
package micdc_pkg;

  localparam int OUT_REM_W = 11;
  localparam int LIMIT_W   = 7;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_LP_ALPHA   = 3'd0;
  localparam logic [2:0] REG_DC_SHIFT   = 3'd1;
  localparam logic [2:0] REG_GAIN_SHIFT = 3'd2;
  localparam logic [2:0] REG_PHASE_STEP = 3'd3;
  localparam logic [2:0] REG_ADC_MAX    = 3'd4;

  localparam logic [13:0] ALPHA_ONE = 14'd8192;

  localparam logic [13:0] RST_LP_ALPHA   = 14'd2048;
  localparam logic [3:0]  RST_DC_SHIFT   = 4'd8;
  localparam logic [3:0]  RST_GAIN_SHIFT = 4'd2;
  localparam logic [15:0] RST_PHASE_STEP = 16'd20971;
  localparam logic [11:0] RST_ADC_MAX    = 12'd4095;
  localparam logic [12:0] RST_DC_LEVEL   = 13'd2048;

  typedef struct packed {
    logic [13:0] lp_alpha;
    logic [3:0]  dc_shift;
    logic [3:0]  gain_shift;
    logic [15:0] phase_step;
    logic [11:0] adc_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
  } cmd_t;

endpackage

// ===== rtl/micdc_front.sv =====
module micdc_front #(
  parameter int MAX_READ = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  micdc_pkg::cfg_t        cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_op,
  input  logic [11:0]            in_raw_sample,
  input  logic [6:0]             in_read_limit,
  output logic                   q_push,
  output micdc_pkg::cmd_t        q_push_cmd,
  input  logic                   q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL1 = 2'd1;
  localparam logic [1:0] F_MUL2 = 2'd2;
  localparam logic [1:0] F_GAIN = 2'd3;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic signed [12:0]  dc_level_r, dc_level_nxt;
  logic signed [15:0]  lp_r, lp_nxt;
  logic [15:0]         phase_r, phase_nxt;
  logic signed [13:0]  cent_r, cent_nxt;
  logic signed [29:0]  prod_r, prod_nxt;
  logic                keep_r, keep_nxt;

  logic                accept;
  logic [11:0]         raw_c;
  logic signed [13:0]  dc_ext_c, diff_c, step_c, dc_new_c, raw_ext_c;
  logic [16:0]         phase_sum_c;
  logic [13:0]         alpha_c, beta_c;
  logic signed [30:0]  prod2_c, acc_c;
  logic signed [17:0]  shr_c;
  logic signed [31:0]  amp_c;
  logic [6:0]          lim_c;

  assign in_stall = (state_r != F_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    raw_c       = (in_raw_sample > cfg.adc_max) ? cfg.adc_max : in_raw_sample;
    raw_ext_c   = $signed({2'b00, raw_c});
    dc_ext_c    = $signed({dc_level_r[12], dc_level_r});
    diff_c      = raw_ext_c - dc_ext_c;
    step_c      = diff_c >>> cfg.dc_shift;
    dc_new_c    = dc_ext_c + step_c;
    phase_sum_c = {1'b0, phase_r} + {1'b0, cfg.phase_step};
    alpha_c     = (cfg.lp_alpha > micdc_pkg::ALPHA_ONE) ? micdc_pkg::ALPHA_ONE : cfg.lp_alpha;
    beta_c      = micdc_pkg::ALPHA_ONE - alpha_c;
    prod2_c     = lp_r * $signed({1'b0, beta_c});
    acc_c       = prod2_c + $signed({prod_r[29], prod_r});
    shr_c       = acc_c[30:13];
    amp_c       = $signed({{16{lp_r[15]}}, lp_r}) <<< cfg.gain_shift;
    lim_c       = (in_read_limit > 7'(MAX_READ)) ? 7'(MAX_READ) : in_read_limit;
  end

  always_comb begin
    state_nxt    = state_r;
    dc_level_nxt = dc_level_r;
    lp_nxt       = lp_r;
    phase_nxt    = phase_r;
    cent_nxt     = cent_r;
    prod_nxt     = prod_r;
    keep_nxt     = keep_r;
    q_push       = 1'b0;
    q_push_cmd   = '0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_op == micdc_pkg::OP_PUSH) begin
            dc_level_nxt = dc_new_c[12:0];
            cent_nxt     = raw_ext_c - dc_new_c;
            phase_nxt    = phase_sum_c[15:0];
            keep_nxt     = phase_sum_c[16];
            state_nxt    = F_MUL1;
          end else if (in_op == micdc_pkg::OP_READ && in_read_limit != 7'd0) begin
            q_push          = 1'b1;
            q_push_cmd.kind = micdc_pkg::CMD_READ;
            q_push_cmd.data = {9'd0, lim_c};
          end else if (in_op == micdc_pkg::OP_CLEAR) begin
            q_push          = 1'b1;
            q_push_cmd.kind = micdc_pkg::CMD_CLEAR;
          end
        end
      end
      F_MUL1: begin
        prod_nxt  = cent_r * $signed({1'b0, alpha_c});
        state_nxt = F_MUL2;
      end
      F_MUL2: begin
        lp_nxt    = sat16($signed({{14{shr_c[17]}}, shr_c}));
        state_nxt = keep_r ? F_GAIN : F_IDLE;
      end
      F_GAIN: begin
        if (!q_full) begin
          q_push          = 1'b1;
          q_push_cmd.kind = micdc_pkg::CMD_PUSH;
          q_push_cmd.data = sat16(amp_c);
          state_nxt       = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      dc_level_r <= micdc_pkg::RST_DC_LEVEL;
      lp_r       <= '0;
      phase_r    <= '0;
      keep_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dc_level_r <= dc_level_nxt;
      lp_r       <= lp_nxt;
      phase_r    <= phase_nxt;
      keep_r     <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cent_r <= cent_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/micdc_queue.sv =====
module micdc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  micdc_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output micdc_pkg::cmd_t head
);

  micdc_pkg::cmd_t                      slot_r [micdc_pkg::Q_DEPTH];
  logic [micdc_pkg::Q_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [micdc_pkg::Q_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [micdc_pkg::Q_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                                 do_push, do_pop;

  assign full     = (cnt_r == micdc_pkg::Q_CNT_W'(micdc_pkg::Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/micdc_back.sv =====
module micdc_back #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_nonempty,
  input  micdc_pkg::cmd_t                        q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [15:0]                     out_pcm_sample,
  output logic                                   out_valid_res,
  output logic                                   out_last,
  output logic [micdc_pkg::OUT_REM_W-1:0]        out_remaining
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic [15:0]                         mem [RING_DEPTH];
  logic [15:0]                         rd_data_r;

  logic                                state_r, state_nxt;
  logic [AW-1:0]                       wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]                       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                       fill_r, fill_nxt;
  logic [micdc_pkg::LIMIT_W-1:0]       cnt_r, cnt_nxt;

  logic                                s1_valid_r, s1_valid_nxt;
  logic                                s1_has_r, s1_has_nxt;
  logic                                s1_last_r, s1_last_nxt;
  logic [micdc_pkg::OUT_REM_W-1:0]     s1_rem_r, s1_rem_nxt;

  logic                                out_valid_r;
  logic signed [15:0]                  out_pcm_r;
  logic                                out_has_r;
  logic                                out_last_r;
  logic [micdc_pkg::OUT_REM_W-1:0]     out_rem_r;

  logic                                out_load, s1_free;
  logic                                rd_en, wr_en;
  logic [CW-1:0]                       fill_dec_c;
  logic [31:0]                         rem_wide_c;

  assign out_load   = !out_valid_r || !out_stall;
  assign s1_free    = !s1_valid_r || out_load;
  assign fill_dec_c = fill_r - 1'b1;
  assign rem_wide_c = 32'(fill_dec_c);

  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;
  assign out_valid_res  = out_has_r;
  assign out_last       = out_last_r;
  assign out_remaining  = out_rem_r;

  always_comb begin
    state_nxt    = state_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    s1_valid_nxt = out_load ? 1'b0 : s1_valid_r;
    s1_has_nxt   = s1_has_r;
    s1_last_nxt  = s1_last_r;
    s1_rem_nxt   = s1_rem_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_nonempty && s1_free) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            micdc_pkg::CMD_PUSH: begin
              wr_en      = 1'b1;
              wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
              if (fill_r < FULL_CNT) begin
                fill_nxt = fill_r + 1'b1;
              end else begin
                rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
              end
            end
            micdc_pkg::CMD_CLEAR: begin
              wr_idx_nxt = '0;
              rd_idx_nxt = '0;
              fill_nxt   = '0;
            end
            micdc_pkg::CMD_READ: begin
              if (fill_r == '0) begin
                s1_valid_nxt = 1'b1;
                s1_has_nxt   = 1'b0;
                s1_last_nxt  = 1'b1;
                s1_rem_nxt   = '0;
              end else begin
                cnt_nxt   = q_head.data[micdc_pkg::LIMIT_W-1:0];
                state_nxt = B_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      B_RUN: begin
        if (s1_free) begin
          rd_en        = 1'b1;
          rd_idx_nxt   = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
          fill_nxt     = fill_dec_c;
          cnt_nxt      = cnt_r - 1'b1;
          s1_valid_nxt = 1'b1;
          s1_has_nxt   = 1'b1;
          s1_last_nxt  = (cnt_r == micdc_pkg::LIMIT_W'(1)) || (fill_r == CW'(1));
          s1_rem_nxt   = rem_wide_c[micdc_pkg::OUT_REM_W-1:0];
          if (s1_last_nxt) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_r] <= q_head.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_has_r  <= s1_has_nxt;
    s1_last_r <= s1_last_nxt;
    s1_rem_r  <= s1_rem_nxt;
    if (out_load) begin
      out_pcm_r  <= s1_has_r ? $signed(rd_data_r) : 16'sd0;
      out_has_r  <= s1_has_r;
      out_last_r <= s1_last_r;
      out_rem_r  <= s1_rem_r;
    end
  end

endmodule

// ===== rtl/mic_dc_lowpass_decimator_ring.sv =====
// Microphone sample conditioner: DC blocker, one-pole low-pass, fractional
// decimator and a RING_DEPTH-entry output ring. A push word occupies the input
// side through the F_MUL1 and F_MUL2 states, and also F_GAIN when the decimator
// keeps the sample, which waits while the command queue is full. The filter
// sequencer runs the two low-pass multiplies one per cycle. Read and clear words
// are taken in 1 cycle while the command queue has room. The ring side applies
// a queued push or clear from B_IDLE. A read moves from B_IDLE to B_RUN and then
// streams one popped sample per cycle, while the output does not stall, through
// the ring's single read port. The first result of a read passes the command
// queue, B_RUN, the stage-1 register and the output register; an empty-ring read
// skips B_RUN and gives one result with valid_res low.
module mic_dc_lowpass_decimator_ring #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_READ   = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic [11:0]                         in_raw_sample,
  input  logic [6:0]                          in_read_limit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_pcm_sample,
  output logic                                out_valid_res,
  output logic                                out_last,
  output logic [micdc_pkg::OUT_REM_W-1:0]     out_remaining
);

  micdc_pkg::cfg_t cfg_r;
  micdc_pkg::cmd_t push_cmd, head_cmd;
  logic            q_push, q_full, q_pop, q_nonempty;
  logic            reg_wr;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lp_alpha   <= micdc_pkg::RST_LP_ALPHA;
      cfg_r.dc_shift   <= micdc_pkg::RST_DC_SHIFT;
      cfg_r.gain_shift <= micdc_pkg::RST_GAIN_SHIFT;
      cfg_r.phase_step <= micdc_pkg::RST_PHASE_STEP;
      cfg_r.adc_max    <= micdc_pkg::RST_ADC_MAX;
    end else if (reg_wr) begin
      unique case (reg_idx)
        micdc_pkg::REG_LP_ALPHA:   cfg_r.lp_alpha   <= pwdata[13:0];
        micdc_pkg::REG_DC_SHIFT:   cfg_r.dc_shift   <= pwdata[3:0];
        micdc_pkg::REG_GAIN_SHIFT: cfg_r.gain_shift <= pwdata[3:0];
        micdc_pkg::REG_PHASE_STEP: cfg_r.phase_step <= pwdata[15:0];
        micdc_pkg::REG_ADC_MAX:    cfg_r.adc_max    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      micdc_pkg::REG_LP_ALPHA:   prdata = {18'd0, cfg_r.lp_alpha};
      micdc_pkg::REG_DC_SHIFT:   prdata = {28'd0, cfg_r.dc_shift};
      micdc_pkg::REG_GAIN_SHIFT: prdata = {28'd0, cfg_r.gain_shift};
      micdc_pkg::REG_PHASE_STEP: prdata = {16'd0, cfg_r.phase_step};
      micdc_pkg::REG_ADC_MAX:    prdata = {20'd0, cfg_r.adc_max};
      default:                   prdata = '0;
    endcase
  end

  micdc_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_raw_sample (in_raw_sample),
    .in_read_limit (in_read_limit),
    .q_push        (q_push),
    .q_push_cmd    (push_cmd),
    .q_full        (q_full)
  );

  micdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head_cmd)
  );

  micdc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pcm_sample (out_pcm_sample),
    .out_valid_res  (out_valid_res),
    .out_last       (out_last),
    .out_remaining  (out_remaining)
  );

endmodule
